### sv/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared widths, defaults and the controller state type for the sample mean
// and standard deviation block.
// ----------------------------------------------------------------------------
package smsd_pkg;

  localparam int unsigned SAMPLE_W            = 16;
  localparam int unsigned DATA_W              = 15;
  localparam int unsigned TOTAL_W             = 8;
  localparam int unsigned VAR_W               = 2 * DATA_W;
  localparam int unsigned ROOT_W              = DATA_W;
  localparam int unsigned MAX_SAMPLES_DEFAULT = 128;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_MEAN_START,
    ST_MEAN,
    ST_SQUARE,
    ST_VAR,
    ST_ROOT,
    ST_DONE
  } smsd_state_e;

endpackage

### sv/sample_mean_std_deviation_core.sv
// ----------------------------------------------------------------------------
// sample_mean_std_deviation_core
// Collects positive Q8.8 samples and reports count, mean and population
// standard deviation of each finished set.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                Payload
// in       in   in_valid_i / in_stall_o   sample_i
// out      out  out_valid_o / out_stall_i sample_total_o, mean_value_o,
//                                         std_deviation_o
//
// A positive sample is written to the sample memory, and while the set stays
// open the next item can follow in the next cycle.
// The item that ends a set stalls the input while the set is processed: the
// bit-serial divider forms the mean, the stored samples are read back and
// squared, the divider forms the variance and the 15-step root follows.
// Reset clears the count and the sums; the sample memory is not cleared.
// A waiting result does not block collection of the next set.
// ----------------------------------------------------------------------------
module sample_mean_std_deviation_core #(
  parameter int unsigned MAX_SAMPLES = smsd_pkg::MAX_SAMPLES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [smsd_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [smsd_pkg::TOTAL_W-1:0]        sample_total_o,
  output logic [smsd_pkg::DATA_W-1:0]         mean_value_o,
  output logic [smsd_pkg::DATA_W-1:0]         std_deviation_o
);
  import smsd_pkg::*;

  localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = DATA_W + CNT_W;
  localparam int unsigned SQ_W   = VAR_W + CNT_W;

  smsd_state_e state_q, state_d;

  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   issue_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SQ_W-1:0]    sq_sum_q;
  logic [DATA_W-1:0]  mean_q;
  logic [ROOT_W-1:0]  dev_q;
  logic               rd_valid_q;
  logic               prod_valid_q;
  logic [VAR_W-1:0]   prod_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] total_q;
  logic [DATA_W-1:0]  mean_out_q;
  logic [DATA_W-1:0]  dev_out_q;

  logic               in_accept;
  logic               positive;
  logic               last_slot;
  logic               finish;
  logic               empty_set;
  logic               rd_en;
  logic               pass_done;
  logic               out_free;
  logic               div_start;
  logic               sqrt_start;
  logic               load_out;
  logic [DATA_W-1:0]  rdata;
  logic [DATA_W-1:0]  diff;
  logic [SQ_W-1:0]    dividend;
  logic               div_done;
  logic [SQ_W-1:0]    quotient;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  root;

  assign in_accept = in_valid_i && !in_stall_o;
  assign positive  = !sample_i[SAMPLE_W-1] && (sample_i != '0);
  assign last_slot = count_q == CNT_W'(MAX_SAMPLES - 1);
  assign finish    = !positive || last_slot;
  assign empty_set = !positive && (count_q == '0);
  assign rd_en     = (state_q == ST_SQUARE) && (issue_q < count_q);
  assign pass_done = (issue_q == count_q) && !rd_valid_q && !prod_valid_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign diff      = (rdata >= mean_q) ? (rdata - mean_q) : (mean_q - rdata);
  assign dividend  = (state_q == ST_MEAN_START) ? SQ_W'(sum_q) : sq_sum_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_accept && finish) begin
          state_d = empty_set ? ST_DONE : ST_MEAN_START;
        end
      end
      ST_MEAN_START: state_d = ST_MEAN;
      ST_MEAN: begin
        if (div_done) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (pass_done) begin
          state_d = ST_VAR;
        end
      end
      ST_VAR: begin
        if (div_done) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      ST_COLLECT:    in_stall_o = 1'b0;
      ST_MEAN_START: div_start  = 1'b1;
      ST_MEAN:       ;
      ST_SQUARE:     div_start  = pass_done;
      ST_VAR:        sqrt_start = div_done;
      ST_ROOT:       ;
      ST_DONE:       load_out   = out_free;
      default:       ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_COLLECT;
      count_q      <= '0;
      sum_q        <= '0;
      sq_sum_q     <= '0;
      issue_q      <= '0;
      rd_valid_q   <= 1'b0;
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_valid_q   <= rd_en;
      prod_valid_q <= rd_valid_q;
      if (state_q == ST_COLLECT && in_accept && positive) begin
        count_q <= count_q + 1'b1;
        sum_q   <= sum_q + SUM_W'(sample_i[DATA_W-1:0]);
      end
      if (rd_en) begin
        issue_q <= issue_q + 1'b1;
      end
      if (prod_valid_q) begin
        sq_sum_q <= sq_sum_q + SQ_W'(prod_q);
      end
      if (load_out) begin
        count_q     <= '0;
        sum_q       <= '0;
        sq_sum_q    <= '0;
        issue_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      prod_q <= diff * diff;
    end
    if (state_q == ST_COLLECT && in_accept && empty_set) begin
      mean_q <= '0;
      dev_q  <= '0;
    end
    if (state_q == ST_MEAN && div_done) begin
      mean_q <= quotient[DATA_W-1:0];
    end
    if (state_q == ST_ROOT && sqrt_done) begin
      dev_q <= root;
    end
    if (load_out) begin
      total_q    <= TOTAL_W'(count_q);
      mean_out_q <= mean_q;
      dev_out_q  <= dev_q;
    end
  end

  smsd_store #(
    .DEPTH  (MAX_SAMPLES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_COLLECT && in_accept && positive),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (sample_i[DATA_W-1:0]),
    .re_i    (rd_en),
    .raddr_i (issue_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  smsd_divider #(
    .DIVIDEND_W (SQ_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  smsd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (quotient[VAR_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign out_valid_o     = out_valid_q;
  assign sample_total_o  = total_q;
  assign mean_value_o    = mean_out_q;
  assign std_deviation_o = dev_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SAMPLES))
    else $error("sample count exceeds the store depth");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_MEAN || state_q == ST_VAR))
    else $error("divider finished outside a division state");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=>
      (out_valid_o && state_q == ST_COLLECT && count_q == '0))
    else $error("result load did not clear the set");

endmodule

### sv/smsd_store.sv
// ----------------------------------------------------------------------------
// smsd_store
// Sample memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module smsd_store #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned ADDR_W = 7
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [smsd_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [smsd_pkg::DATA_W-1:0] rdata_o
);
  import smsd_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/smsd_divider.sv
// ----------------------------------------------------------------------------
// smsd_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smsd_divider #(
  parameter int unsigned DIVIDEND_W = 38,
  parameter int unsigned DIVISOR_W  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);
  import smsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? DIVISOR_W'(trial - {1'b0, divisor_i}) : DIVISOR_W'(trial);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### sv/smsd_isqrt.sv
// ----------------------------------------------------------------------------
// smsd_isqrt
// Floor square root, one root bit per cycle by digit recurrence.
// ----------------------------------------------------------------------------
module smsd_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [smsd_pkg::VAR_W-1:0]  value_i,
  output logic                        done_o,
  output logic [smsd_pkg::ROOT_W-1:0] root_o
);
  import smsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 2;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [VAR_W-1:0]  val_q, val_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;
  logic              fits;

  assign shifted = {rem_q, val_q[VAR_W-1 -: 2]};
  assign trial   = (REM_W + 2)'({root_q, 2'b01});
  assign fits    = shifted >= trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      cnt_d  = CNT_W'(ROOT_W);
      busy_d = 1'b1;
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d  = {val_q[VAR_W-3:0], 2'b00};
      rem_d  = fits ? REM_W'(shifted - trial) : REM_W'(shifted);
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
